// File: rtl/core/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared constants and types for the minimal standard random range block.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int unsigned VAL_W     = 31;
  localparam int unsigned MULT_W    = 15;
  localparam int unsigned PROD_W    = VAL_W + MULT_W;
  localparam int unsigned DIV_STEPS = VAL_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [MULT_W-1:0] MS_MULT    = 15'd16807;
  localparam logic [VAL_W-1:0]  MS_MODULUS = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [VAL_W-1:0] seed;
    logic [VAL_W-1:0] limit;
  } job_t;

endpackage

// File: rtl/core/minimal_standard_random_mod_n.sv
// ----------------------------------------------------------------------------
// minimal_standard_random_mod_n
// Minimal standard generator reduced to a caller-given range.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive range_limit (n >= 1) with push; a request is taken
//   when push is high and full is low. Each request advances the 31-bit
//   seed (seed * 16807 mod 2^31-1) and yields one random_value in 0..n-1.
//   Output queue: random_value is valid while empty is low; pop takes it.
//   Path from request to result: the product is registered at the accepting
//   edge, then folded into the job queue, dequeued into the divider, taken
//   through 31 divider steps and loaded into the output register.
//   The restoring divider produces one quotient bit per cycle and works on
//   one job at a time; the front takes no new request until the last one is
//   folded into its two-entry job queue, and waits while that queue is full.
//   Reset: rst (synchronous) sets the seed to 1 and empties all queues.
//   Stall: a held result stops the divider after its current job; the job
//   queue then fills and full is raised. Nothing is dropped.
// ----------------------------------------------------------------------------
module minimal_standard_random_mod_n (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [msr_pkg::VAL_W-1:0] range_limit,
  output logic                      empty,
  input  logic                      pop,
  output logic [msr_pkg::VAL_W-1:0] random_value
);
  import msr_pkg::*;

  logic job_valid;
  job_t job_in;
  job_t job_out;
  logic q_full;
  logic q_empty;
  logic take;

  msr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .range_limit (range_limit),
    .job_valid   (job_valid),
    .job         (job_in),
    .q_full      (q_full)
  );

  msr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_valid),
    .wr_job  (job_in),
    .q_full  (q_full),
    .rd      (take),
    .rd_job  (job_out),
    .q_empty (q_empty)
  );

  msr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .job          (job_out),
    .take         (take),
    .empty        (empty),
    .pop          (pop),
    .random_value (random_value)
  );

endmodule

// File: rtl/core/msr_front.sv
// ----------------------------------------------------------------------------
// msr_front
// Takes requests, advances the seed (multiply, then fold modulo 2^31-1)
// and hands the new seed with its limit to the job queue.
// ----------------------------------------------------------------------------
module msr_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [msr_pkg::VAL_W-1:0] range_limit,
  output logic                     job_valid,
  output msr_pkg::job_t            job,
  input  logic                     q_full
);
  import msr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FOLD = 1'b1;

  logic              state;
  logic [VAL_W-1:0]  seed;
  logic [VAL_W-1:0]  seed_in;
  logic [VAL_W-1:0]  limit;
  logic [PROD_W-1:0] prod;
  logic [VAL_W:0]    fold_sum;
  logic [VAL_W-1:0]  fold;

  assign seed_in  = (seed == '0) ? VAL_W'(1) : seed;
  assign fold_sum = {1'b0, prod[VAL_W-1:0]} + (VAL_W+1)'(prod[PROD_W-1:VAL_W]);
  assign fold     = (fold_sum >= {1'b0, MS_MODULUS}) ?
                    VAL_W'(fold_sum - {1'b0, MS_MODULUS}) : fold_sum[VAL_W-1:0];

  assign full      = (state != ST_IDLE);
  assign job_valid = (state == ST_FOLD);
  assign job.seed  = fold;
  assign job.limit = limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seed  <= VAL_W'(1);
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (push) begin
            prod  <= PROD_W'(seed_in) * PROD_W'(MS_MULT);
            limit <= range_limit;
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (!q_full) begin
            seed  <= fold;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_seed_nonzero: assert property (@(posedge clk) disable iff (rst)
    seed != '0 && seed != MS_MODULUS)
    else $error("seed left the generator's orbit");

  a_fold_reduced: assert property (@(posedge clk) disable iff (rst)
    state == ST_FOLD |-> fold < MS_MODULUS && fold != '0)
    else $error("fold not fully reduced");

endmodule

// File: rtl/core/msr_queue.sv
// ----------------------------------------------------------------------------
// msr_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module msr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  msr_pkg::job_t wr_job,
  output logic          q_full,
  input  logic          rd,
  output msr_pkg::job_t rd_job,
  output logic          q_empty
);
  import msr_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2 && (count == 2'd1) == (wr_ptr != rd_ptr))
    else $error("queue pointers and count disagree");

endmodule

// File: rtl/core/msr_back.sv
// ----------------------------------------------------------------------------
// msr_back
// Restoring divider, one quotient bit per cycle; the remainder goes to a
// one-deep output register.
// ----------------------------------------------------------------------------
module msr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  msr_pkg::job_t             job,
  output logic                      take,
  output logic                      empty,
  input  logic                      pop,
  output logic [msr_pkg::VAL_W-1:0] random_value
);
  import msr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [VAL_W:0]   rem;
  logic [VAL_W-1:0] quo;
  logic [VAL_W-1:0] div;
  logic [CNT_W-1:0] cnt;
  logic             out_valid;
  logic [VAL_W:0]   rem_sh;
  logic             ge;
  logic             load_out;

  assign take     = (state == ST_IDLE) && !q_empty;
  assign rem_sh   = {rem[VAL_W-1:0], quo[VAL_W-1]};
  assign ge       = rem_sh >= {1'b0, div};
  assign load_out = (state == ST_DONE) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid    <= 1'b1;
        random_value <= rem[VAL_W-1:0];
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            rem   <= '0;
            quo   <= job.seed;
            div   <= job.limit;
            cnt   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem <= ge ? rem_sh - {1'b0, div} : rem_sh;
          quo <= {quo[VAL_W-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && div != '0 |-> rem < {1'b0, div})
    else $error("remainder not below limit");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> cnt <= CNT_W'(DIV_STEPS - 1))
    else $error("divider step count overran");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for minimal_standard_random_mod_n. A short table of directed
// range limits (extremes, powers of two, the zero limit) is followed by random
// limits. Every request advances a local copy of the 31-bit generator seed, and
// each popped random_value is compared with the oldest expected value. Both
// queue sides insert random idle cycles, with stretches of none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import msr_pkg::*;

  localparam int unsigned     RANDOM_REQUESTS = 600;
  localparam int unsigned     CYCLE_LIMIT     = 200000;
  localparam int unsigned     DRAIN_CYCLES    = 50;
  localparam logic [VAL_W-1:0] LIMIT_MAX      = '1;

  typedef struct packed {
    logic [VAL_W-1:0] limit;
    logic             known;
    logic [VAL_W-1:0] value;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 20;

  // Values typed in follow from seed 1: 16807, 282475249, 1622650073, 984943658
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{LIMIT_MAX,        1'b1, 31'd16807},
    '{31'd0,            1'b1, 31'd282475249},
    '{31'd1,            1'b1, 31'd0},
    '{LIMIT_MAX,        1'b1, 31'd984943658},
    '{31'd2,            1'b0, 31'd0},
    '{31'd3,            1'b0, 31'd0},
    '{31'd7,            1'b0, 31'd0},
    '{31'd10,           1'b0, 31'd0},
    '{31'd16807,        1'b0, 31'd0},
    '{31'h0000_FFFF,    1'b0, 31'd0},
    '{31'h0001_0000,    1'b0, 31'd0},
    '{31'h4000_0000,    1'b0, 31'd0},
    '{31'h2AAA_AAAA,    1'b0, 31'd0},
    '{31'h5555_5555,    1'b0, 31'd0},
    '{31'h7FFF_FFFE,    1'b0, 31'd0},
    '{31'h7FFF_FFFD,    1'b0, 31'd0},
    '{31'd0,            1'b0, 31'd0},
    '{31'd1,            1'b0, 31'd0},
    '{31'd1000000007,   1'b0, 31'd0},
    '{31'h3FFF_FFFF,    1'b0, 31'd0}
  };

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             push        = 1'b0;
  logic             pop         = 1'b0;
  logic [VAL_W-1:0] range_limit = '0;
  logic             full;
  logic             empty;
  logic [VAL_W-1:0] random_value;

  logic [VAL_W-1:0] gen_seed;
  logic [VAL_W-1:0] expected_values [$];
  int unsigned      mismatches;
  int unsigned      cycles;
  bit               send_burst;
  bit               take_burst;

  minimal_standard_random_mod_n u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .range_limit  (range_limit),
    .empty        (empty),
    .pop          (pop),
    .random_value (random_value)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("minimal_standard_random_mod_n regression: fail");
      $finish;
    end
  end

  // Advances the generator seed and reduces it to the range limit (a zero limit returns the seed).
  function automatic logic [VAL_W-1:0] predict_random_value(input logic [VAL_W-1:0] limit);
    logic [63:0] product;
    logic [VAL_W-1:0] s;
    s = (gen_seed == '0) ? VAL_W'(1) : gen_seed;
    product = 64'(s) * 64'd16807;
    gen_seed = VAL_W'(product % 64'h7FFF_FFFF);
    if (limit == '0) return gen_seed;
    return gen_seed % limit;
  endfunction

  function automatic logic [VAL_W-1:0] draw_limit();
    int unsigned sel;
    logic [VAL_W-1:0] limit;
    sel = $urandom_range(0, 63);
    if (sel == 0) begin
      limit = '0;
    end else if (sel < 16) begin
      limit = VAL_W'($urandom_range(1, 64));
    end else if (sel < 24) begin
      limit = VAL_W'(1) << $urandom_range(0, VAL_W - 1);
    end else if (sel < 30) begin
      limit = LIMIT_MAX - VAL_W'($urandom_range(0, 3));
    end else begin
      limit = VAL_W'($urandom());
      if (limit == '0) limit = VAL_W'(1);
    end
    return limit;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [VAL_W-1:0] limit, input logic known,
                              input logic [VAL_W-1:0] value);
    int unsigned gap;
    logic [VAL_W-1:0] predicted;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    range_limit <= limit;
    do @(posedge clk); while (full);
    predicted = predict_random_value(limit);
    expected_values.push_back(known ? value : predicted);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (expected_values.size() != 0) @(negedge clk);
  endtask

  task automatic take_results();
    int unsigned gap;
    logic [VAL_W-1:0] want;
    forever begin
      gap = take_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: random_value %0d", random_value);
      end else begin
        want = expected_values.pop_front();
        if (random_value !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("random_value mismatch: expected %0d, got %0d", want, random_value);
        end
      end
      @(negedge clk);
    end
  endtask

  initial begin
    gen_seed   = VAL_W'(1);
    mismatches = 0;
    cycles     = 0;
    send_burst = 1'b0;
    take_burst = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    fork
      take_results();
    join_none

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_request(DIRECTED[i].limit, DIRECTED[i].known, DIRECTED[i].value);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 50 == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
        take_burst = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_REQUESTS / 2) begin
        push <= 1'b0;
        wait_for_results();
      end
      send_request(draw_limit(), 1'b0, '0);
    end
    push <= 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("minimal_standard_random_mod_n regression: pass");
    end else begin
      $display("minimal_standard_random_mod_n regression: fail");
    end
    $finish;
  end

endmodule
